// ===== design/prq_pkg.sv =====
// Shared definitions for the priority ready queue.
// Holds the queue depth, derived widths, action and status codes, and the
// command bundle from controller to datapath. No dependencies.
package prq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int PRIO_W      = 3;
  localparam int OCC_W       = 7;
  localparam int STATUS_W    = 2;

  // Requested operation
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the incoming beat
    logic compare;  // register per-cell compare flags
    logic update;   // shift the cell chain and set status
  } prq_cmd_t;

endpackage

// ===== design/prq_ctrl.sv =====
// Sequencer for the priority ready queue.
// Walks each beat through capture, compare, update and response.
// Depends on prq_pkg.
module prq_ctrl
  import prq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output prq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_RESP
  } state_t;

  state_t state;

  // Commands decoded from state and the input handshake
  always_comb begin
    cmd.load    = in_valid && !in_stall;
    cmd.compare = (state == S_CMP);
    cmd.update  = (state == S_UPD);
  end

  // State and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_CMP;
            in_stall <= 1'b1;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state     <= S_RESP;
          out_valid <= 1'b1;
        end
        S_RESP: begin
          if (!out_stall) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
            in_stall  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is offered only while no new beat can enter
  a_resp_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result offered while input open");

  // An accepted beat yields a result after its compare and update states
  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> ##3 out_valid) else $error("result missing after accept");

  // Response is held until taken
  a_resp_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule

// ===== design/prq_datapath.sv =====
// Sorted cell chain of the priority ready queue.
// Each cell holds an identifier, a priority and a used bit; all cells
// compare in parallel, then shift to open or close a gap. Depends on prq_pkg.
module prq_datapath
  import prq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  prq_cmd_t            cmd,
  input  logic                action,
  input  logic [ID_W-1:0]     task_id,
  input  logic [PRIO_W-1:0]   task_priority,
  output logic [STATUS_W-1:0] status,
  output logic                head_valid,
  output logic [ID_W-1:0]     head_id,
  output logic [PRIO_W-1:0]   head_priority,
  output logic [OCC_W-1:0]    occupancy
);

  // Captured beat
  logic              act_q;
  logic [ID_W-1:0]   id_q;
  logic [PRIO_W-1:0] prio_q;

  // Cell storage
  logic [ID_W-1:0]        cell_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0]      cell_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] used;
  logic [CNT_W-1:0]       cnt;

  // Registered compare flags
  logic [QUEUE_DEPTH-1:0] le_q;     // used and priority not above new one
  logic [QUEUE_DEPTH-1:0] match_q;  // used and identifier equal

  logic [QUEUE_DEPTH-1:0] le_prev;
  logic [QUEUE_DEPTH-1:0] after;    // at or past first match
  logic [QUEUE_DEPTH-1:0] used_nxt;
  logic [ID_W-1:0]        prv_id    [QUEUE_DEPTH];
  logic [PRIO_W-1:0]      prv_prio  [QUEUE_DEPTH];
  logic [ID_W-1:0]        nxt_id    [QUEUE_DEPTH];
  logic [PRIO_W-1:0]      nxt_prio  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] used_prv;
  logic                   full;
  logic                   found;
  logic                   do_ins;
  logic                   do_rem;

  // Capture the beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= action;
      id_q   <= task_id;
      prio_q <= task_priority;
    end
  end

  // Parallel compare over every cell
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        le_q[i]    <= used[i] && (cell_prio[i] <= prio_q);
        match_q[i] <= used[i] && (cell_id[i] == id_q);
      end
    end
  end

  // Inclusive prefix OR of matches, log-depth
  always_comb begin
    after = match_q;
    for (int l = 0; (1 << l) < QUEUE_DEPTH; l++) begin
      after = after | (after << (1 << l));
    end
  end

  // Neighbor views of the chain
  assign le_prev  = {le_q[QUEUE_DEPTH-2:0], 1'b1};
  assign used_nxt = {1'b0, used[QUEUE_DEPTH-1:1]};
  assign used_prv = {used[QUEUE_DEPTH-2:0], 1'b1};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_nbr
    if (i == 0) begin : g_first
      assign prv_id[i]   = id_q;
      assign prv_prio[i] = prio_q;
    end else begin : g_mid
      assign prv_id[i]   = cell_id[i-1];
      assign prv_prio[i] = cell_prio[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt_id[i]   = cell_id[i];
      assign nxt_prio[i] = cell_prio[i];
    end else begin : g_inner
      assign nxt_id[i]   = cell_id[i+1];
      assign nxt_prio[i] = cell_prio[i+1];
    end
  end

  assign full   = (cnt == CNT_W'(QUEUE_DEPTH));
  assign found  = after[QUEUE_DEPTH-1];
  assign do_ins = cmd.update && (act_q == ACT_INSERT) && !full;
  assign do_rem = cmd.update && (act_q == ACT_REMOVE) && found;

  // Cell payload: open a gap at the insert point or close one at the match
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_ins && !le_q[i] && le_prev[i]) begin
        cell_id[i]   <= id_q;
        cell_prio[i] <= prio_q;
      end else if (do_ins && !le_q[i]) begin
        cell_id[i]   <= prv_id[i];
        cell_prio[i] <= prv_prio[i];
      end else if (do_rem && after[i]) begin
        cell_id[i]   <= nxt_id[i];
        cell_prio[i] <= nxt_prio[i];
      end
    end
  end

  // Used bits, count and status
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      cnt    <= '0;
      status <= ST_DONE;
    end else if (cmd.update) begin
      if (act_q == ACT_INSERT) begin
        if (full) begin
          status <= ST_FULL;
        end else begin
          status <= ST_DONE;
          cnt    <= cnt + 1'b1;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!le_q[i]) begin
              used[i] <= used_prv[i];
            end
          end
        end
      end else begin
        if (!found) begin
          status <= ST_NOT_FOUND;
        end else begin
          status <= ST_DONE;
          cnt    <= cnt - 1'b1;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (after[i]) begin
              used[i] <= used_nxt[i];
            end
          end
        end
      end
    end
  end

  // Head of queue
  assign head_valid    = used[0];
  assign head_id       = used[0] ? cell_id[0] : '0;
  assign head_priority = used[0] ? cell_prio[0] : '0;
  assign occupancy     = OCC_W'(cnt);

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH)) else $error("count past depth");

  a_cnt_used: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(cnt)) else $error("count and used bits differ");

  a_used_prefix: assert property (@(posedge clk) disable iff (rst)
    (used[QUEUE_DEPTH-1:1] & ~used[QUEUE_DEPTH-2:0]) == '0)
    else $error("used cells not contiguous from head");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> cnt == $past(cnt) + 1'b1) else $error("insert did not grow queue");

endmodule

// ===== design/priority_ready_queue.sv =====
// Priority ready queue: a sorted queue of task identifiers.
// Beats enter on the input channel, one result per beat leaves on the
// output channel. A beat is action, task_id and task_priority.
// Inserts go behind all tasks of equal or lower priority number, so equal
// priorities are served first in, first out. Removes take out the first
// task with a matching identifier.
// Status is done, not found on a missed remove, or full on a refused insert;
// every result also carries the head task and the occupancy after the beat.
// The queue handles one beat at a time: a taken beat passes a compare step
// and an update step on the cell chain before its result is offered, and no
// new beat enters until that result is taken.
// in_stall stays high from acceptance until the result beat is taken.
// While out_stall is high the result and its fields hold steady.
// Reset (rst, synchronous) empties the queue and opens the input.
// Depends on prq_pkg, prq_ctrl and prq_datapath.
module priority_ready_queue
  import prq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [ID_W-1:0]     task_id,
  input  logic [PRIO_W-1:0]   task_priority,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic                head_valid,
  output logic [ID_W-1:0]     head_id,
  output logic [PRIO_W-1:0]   head_priority,
  output logic [OCC_W-1:0]    occupancy
);

  prq_cmd_t cmd;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  prq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .task_id       (task_id),
    .task_priority (task_priority),
    .status        (status),
    .head_valid    (head_valid),
    .head_id       (head_id),
    .head_priority (head_priority),
    .occupancy     (occupancy)
  );

endmodule
